@@ rtl/core/psa_pkg.sv @@
// shared types and constants for the paged slot allocator
// no dependencies; used by the top level, the controller and the datapath
package psa_pkg;

  localparam int PAGE_W = 4;
  localparam int SLOT_W = 6;

  localparam int PAGE_SLOTS_DEF = 64;
  localparam int MAX_PAGES_DEF  = 16;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [1:0] ST_ALLOC  = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_FREED  = 2'd2;
  localparam logic [1:0] ST_REJECT = 2'd3;

  typedef struct packed {
    logic              req_type;
    logic [PAGE_W-1:0] free_page;
    logic [SLOT_W-1:0] free_slot;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PAGE_W-1:0] got_page;
    logic [SLOT_W-1:0] got_slot;
    logic              page_opened;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic read_done;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_read;
  } stat_t;

endpackage

@@ rtl/core/paged_slot_allocator.sv @@
// paged slot allocator top level: joins controller and datapath
// depends on psa_pkg, psa_ctrl, psa_datapath
//
// usage
//   input channel: in_valid / in_stall / in_data (psa_pkg::req_t). a transaction
//   either allocates a slot or frees one (free_page, free_slot).
//   output channel: out_valid / out_stall / out_data (psa_pkg::rsp_t). exactly one
//   result transaction per request: allocated, all full, freed or free rejected.
//   a request served from a bump count, a page open or a free passes through the
//   S_EVAL and S_DONE states on its way to the output register; when the slot
//   comes from a page's freed stack it also passes S_READ, for the registered
//   read of the stack ram. the block works on one request at a time and in_stall
//   stays high until its result is in the output register.
//   the next request is taken while that result still waits on out_stall.
//   a stalled result holds in the output register until taken.
//   reset clears the open page count and every page's bump count and stack depth;
//   the stack ram needs no clearing since only pushed entries are ever read.
module paged_slot_allocator #(
  parameter int PAGE_SLOTS = psa_pkg::PAGE_SLOTS_DEF,
  parameter int MAX_PAGES  = psa_pkg::MAX_PAGES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  psa_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output psa_pkg::rsp_t out_data
);

  psa_pkg::cmd_t  cmd;
  psa_pkg::stat_t stat;

  psa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  psa_datapath #(
    .PAGE_SLOTS(PAGE_SLOTS),
    .MAX_PAGES (MAX_PAGES)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .in_data (in_data),
    .out_data(out_data)
  );

endmodule

@@ rtl/core/psa_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module psa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/psa_datapath.sv @@
// datapath: per-page bump counts and stack depths, page search, freed-slot stack ram
// depends on psa_pkg and psa_ram
module psa_datapath #(
  parameter int PAGE_SLOTS = psa_pkg::PAGE_SLOTS_DEF,
  parameter int MAX_PAGES  = psa_pkg::MAX_PAGES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  psa_pkg::cmd_t  cmd,
  output psa_pkg::stat_t stat,
  input  psa_pkg::req_t  in_data,
  output psa_pkg::rsp_t  out_data
);

  localparam int PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int OW = $clog2(MAX_PAGES + 1);
  localparam int CW = $clog2(PAGE_SLOTS + 1);
  localparam int SW = $clog2(PAGE_SLOTS);
  localparam longint DEPTH = longint'(MAX_PAGES) * longint'(PAGE_SLOTS);
  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] PS_A = AW'(PAGE_SLOTS);
  localparam logic [CW-1:0] PS_C = CW'(PAGE_SLOTS);

  psa_pkg::req_t req;
  logic [OW-1:0] open_pages;
  logic [CW-1:0] bump_left [MAX_PAGES];
  logic [CW-1:0] stack_top [MAX_PAGES];

  logic [1:0]    res_status;
  logic [PW-1:0] res_page;
  logic [SW-1:0] res_slot;
  logic          res_opened;
  logic [1:0]    res_status_next;
  logic [PW-1:0] res_page_next;
  logic [SW-1:0] res_slot_next;
  logic          res_opened_next;

  logic [MAX_PAGES-1:0] avail;
  logic                 found;
  logic [PW-1:0]        fpg;
  logic [CW-1:0]        f_bump;
  logic [CW-1:0]        f_stack;
  logic                 pg_in_range;
  logic [PW-1:0]        pg_idx;
  logic [CW-1:0]        pg_stack;
  logic                 free_ok;
  logic [PW-1:0]        new_pg;
  logic                 is_full;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [SW-1:0] rd_data;

  always_comb begin
    for (int i = 0; i < MAX_PAGES; i++) begin
      avail[i] = (bump_left[i] != '0) || (stack_top[i] != '0);
    end
    found = 1'b0;
    fpg   = '0;
    for (int i = 0; i < MAX_PAGES; i++) begin
      if (avail[i]) begin
        found = 1'b1;
        fpg   = PW'(i);
      end
    end
    f_bump  = bump_left[fpg];
    f_stack = stack_top[fpg];

    pg_in_range = 32'(req.free_page) < 32'(MAX_PAGES);
    pg_idx      = PW'(req.free_page);
    pg_stack    = pg_in_range ? stack_top[pg_idx] : '0;
    free_ok     = pg_in_range && (32'(req.free_page) < 32'(open_pages)) &&
                  (32'(req.free_slot) < 32'(PAGE_SLOTS)) && (pg_stack < PS_C);

    new_pg  = PW'(open_pages);
    is_full = open_pages == OW'(MAX_PAGES);

    wr_en   = cmd.eval && (req.req_type == psa_pkg::REQ_FREE) && free_ok;
    wr_addr = AW'(AW'(pg_idx) * PS_A) + AW'(pg_stack);
    rd_en   = cmd.eval && (req.req_type == psa_pkg::REQ_ALLOC) && found && (f_bump == '0);
    rd_addr = AW'(AW'(fpg) * PS_A) + AW'(f_stack - CW'(1));

    stat.need_read = rd_en;

    res_status_next = psa_pkg::ST_ALLOC;
    res_page_next   = '0;
    res_slot_next   = '0;
    res_opened_next = 1'b0;
    if (req.req_type == psa_pkg::REQ_ALLOC) begin
      if (found) begin
        res_page_next = fpg;
        res_slot_next = SW'(f_bump - CW'(1));
      end else if (is_full) begin
        res_status_next = psa_pkg::ST_FULL;
      end else begin
        res_page_next   = new_pg;
        res_slot_next   = SW'(PS_C - CW'(1));
        res_opened_next = 1'b1;
      end
    end else begin
      res_status_next = free_ok ? psa_pkg::ST_FREED : psa_pkg::ST_REJECT;
    end
  end

  psa_ram #(
    .WIDTH(SW),
    .DEPTH(int'(DEPTH))
  ) u_stack_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(SW'(req.free_slot)),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      open_pages <= '0;
      for (int i = 0; i < MAX_PAGES; i++) begin
        bump_left[i] <= '0;
        stack_top[i] <= '0;
      end
    end else if (cmd.eval) begin
      if (req.req_type == psa_pkg::REQ_ALLOC) begin
        if (found) begin
          if (f_bump != '0) begin
            bump_left[fpg] <= f_bump - CW'(1);
          end else begin
            stack_top[fpg] <= f_stack - CW'(1);
          end
        end else if (!is_full) begin
          bump_left[new_pg] <= PS_C - CW'(1);
          stack_top[new_pg] <= '0;
          open_pages        <= open_pages + OW'(1);
        end
      end else if (free_ok) begin
        stack_top[pg_idx] <= pg_stack + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req <= in_data;
    end
    if (cmd.eval) begin
      res_status <= res_status_next;
      res_page   <= res_page_next;
      res_slot   <= res_slot_next;
      res_opened <= res_opened_next;
    end else if (cmd.read_done) begin
      res_slot <= rd_data;
    end
    if (cmd.out_load) begin
      out_data.status      <= res_status;
      out_data.got_page    <= psa_pkg::PAGE_W'(res_page);
      out_data.got_slot    <= psa_pkg::SLOT_W'(res_slot);
      out_data.page_opened <= res_opened;
    end
  end

endmodule

@@ rtl/core/psa_ctrl.sv @@
// controller: request sequencing and output valid for the paged slot allocator
// depends on psa_pkg
module psa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output psa_pkg::cmd_t  cmd,
  input  psa_pkg::stat_t stat
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_READ,
    S_DONE
  } state_t;

  state_t state;
  logic   out_free;

  always_comb begin
    out_free      = !out_valid || !out_stall;
    in_stall      = state != S_IDLE;
    cmd.capture   = (state == S_IDLE) && in_valid;
    cmd.eval      = state == S_EVAL;
    cmd.read_done = state == S_READ;
    cmd.out_load  = (state == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          state <= stat.need_read ? S_READ : S_DONE;
        end
        S_READ: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
